// File: hdl/bgbs_pkg.sv
// ----------------------------------------------------------------------------
// bgbs_pkg: shared types and constants for the ball bounce step block
// widths of the fixed-point fields, register map, codes and saturation helpers
// ----------------------------------------------------------------------------
package bgbs_pkg;

	localparam int POS_W   = 21;  // signed Q13.8 position
	localparam int VEL_W   = 24;  // signed Q16.8 velocity
	localparam int MS_W    = 10;
	localparam int GRAV_W  = 20;
	localparam int DAMP_W  = 17;  // Q1.16
	localparam int FIELD_W = 12;
	localparam int START_W = 20;
	localparam int CNT_W   = 8;
	localparam int LINE_W  = 13;  // wall line in whole pixels, signed
	localparam int REFL_W  = 15;
	localparam int SUM_W   = 26;  // headroom for sums before saturation
	localparam int FRAC_W  = 8;

	localparam int MUL_W   = 32;
	localparam int PROD_W  = 2 * MUL_W;
	localparam int QUO_W   = 24;
	localparam int XDIV_W  = 31;

	localparam int DATA_W  = 32;
	localparam int ADDR_W  = 5;

	localparam int BALL_RADIUS_DEF = 16;

	// divide by 1000 as a shift by 3 and a multiply by the reciprocal of 125
	localparam int                 DIV_SHIFT   = 3;
	localparam int                 DIV_ODD     = 125;
	localparam int                 RECIP_SHIFT = 32;
	localparam logic [MUL_W-1:0]   RECIP_125   = 32'd34359738;
	localparam int                 DAMP_SHIFT  = 16;
	localparam int                 DMAG_W      = 25;

	localparam logic [DAMP_W-1:0]  DAMP_RESET = 17'd65536;
	localparam logic [FIELD_W-1:0] FW_RESET   = 12'd640;
	localparam logic [FIELD_W-1:0] FH_RESET   = 12'd480;

	// register indexes
	localparam logic [2:0] REG_START_X  = 3'd0;
	localparam logic [2:0] REG_START_Y  = 3'd1;
	localparam logic [2:0] REG_START_VX = 3'd2;
	localparam logic [2:0] REG_START_VY = 3'd3;
	localparam logic [2:0] REG_DAMP     = 3'd4;
	localparam logic [2:0] REG_FIELD_W  = 3'd5;
	localparam logic [2:0] REG_FIELD_H  = 3'd6;

	// gravity direction codes
	localparam logic [1:0] GDIR_UP    = 2'd0;
	localparam logic [1:0] GDIR_DOWN  = 2'd1;
	localparam logic [1:0] GDIR_LEFT  = 2'd2;
	localparam logic [1:0] GDIR_RIGHT = 2'd3;

	localparam logic [CNT_W-1:0] CNT_MAX = 8'd255;

	localparam logic signed [SUM_W-1:0] POS_MAX_S = 26'sd1048575;
	localparam logic signed [SUM_W-1:0] POS_MIN_S = -26'sd1048576;
	localparam logic signed [SUM_W-1:0] VEL_MAX_S = 26'sd8388607;
	localparam logic signed [SUM_W-1:0] VEL_MIN_S = -26'sd8388608;

	typedef logic signed [POS_W-1:0] pos_t;
	typedef logic signed [VEL_W-1:0] vel_t;
	typedef logic [MUL_W-1:0]        mul_op_t;
	typedef logic [PROD_W-1:0]       prod_t;

	function automatic pos_t sat_pos(input logic signed [SUM_W-1:0] v);
		if (v > POS_MAX_S)
			return POS_W'(POS_MAX_S);
		else if (v < POS_MIN_S)
			return POS_W'(POS_MIN_S);
		else
			return POS_W'(v);
	endfunction

	function automatic vel_t sat_vel(input logic signed [SUM_W-1:0] v);
		if (v > VEL_MAX_S)
			return VEL_W'(VEL_MAX_S);
		else if (v < VEL_MIN_S)
			return VEL_W'(VEL_MIN_S);
		else
			return VEL_W'(v);
	endfunction

endpackage

// File: hdl/bgbs_mul.sv
// ----------------------------------------------------------------------------
// bgbs_mul: shared unsigned multiplier
// one 32 x 32 product per cycle, result registered
// ----------------------------------------------------------------------------
module bgbs_mul import bgbs_pkg::*; (
	input  logic    clk,
	input  mul_op_t a,
	input  mul_op_t b,
	output prod_t   p_q
);

	always_ff @(posedge clk) begin
		p_q <= PROD_W'(a) * PROD_W'(b);
	end

endmodule

// File: hdl/ball_gravity_bounce_step.sv
// ----------------------------------------------------------------------------
// ball_gravity_bounce_step: one euler step of a bouncing ball per tick
// position/velocity update, gravity, wall reflection with damping, stillness
// ----------------------------------------------------------------------------
// usage:
//   the input channel (in_valid/in_stall) carries one tick word: elapsed_ms,
//   gravity_dir, gravity_strength. the output channel (out_valid/out_stall)
//   returns one word per tick: new position, velocity, hit flag, still count.
//   a word is taken at a clock edge where valid is high and stall is low.
//   all multiplies run through one shared 32x32 multiplier under a small
//   sequencer; in_stall stays high while a tick is in work.
//   a tick runs three divides by 1000 (multiply, reciprocal, estimate, fix,
//   apply), for x, y and gravity, then three wall checks (bottom, right, left),
//   a damping multiply sequence (x, y, end) per wall hit, and one finish step.
//   the next tick is taken only from idle, after the result is registered, so
//   a new tick is never taken while the last one is still in work.
//   the result sits in an output register; a new tick is accepted while it
//   waits, and a finished tick holds in its last step while an earlier word is still stalled.
//   reset (arst_n low) clears position, velocity and count to zero and loads
//   the register reset values; the user must write registers over the apb port
//   only while idle, which the block itself does not enforce, and a start position/velocity write loads the ball state.
// ----------------------------------------------------------------------------
module ball_gravity_bounce_step import bgbs_pkg::*; #(
	parameter int BALL_RADIUS = BALL_RADIUS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [ADDR_W-1:0]   paddr,
	input  logic [DATA_W-1:0]   pwdata,
	output logic [DATA_W-1:0]   prdata,
	output logic                pready,
	// tick input
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MS_W-1:0]     elapsed_ms,
	input  logic [1:0]          gravity_dir,
	input  logic [GRAV_W-1:0]   gravity_strength,
	// result output
	output logic                out_valid,
	input  logic                out_stall,
	output logic signed [POS_W-1:0] pos_x,
	output logic signed [POS_W-1:0] pos_y,
	output logic signed [VEL_W-1:0] vel_x,
	output logic signed [VEL_W-1:0] vel_y,
	output logic                hit_wall,
	output logic [CNT_W-1:0]    still_ticks
);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_DIV_MUL = 4'd1;
	localparam logic [3:0] ST_DIV_RCP = 4'd2;
	localparam logic [3:0] ST_DIV_EST = 4'd3;
	localparam logic [3:0] ST_DIV_FIX = 4'd4;
	localparam logic [3:0] ST_APPLY   = 4'd5;
	localparam logic [3:0] ST_WALL    = 4'd6;
	localparam logic [3:0] ST_DMP_X   = 4'd7;
	localparam logic [3:0] ST_DMP_Y   = 4'd8;
	localparam logic [3:0] ST_DMP_END = 4'd9;
	localparam logic [3:0] ST_DONE    = 4'd10;

	localparam logic [1:0] PH_X = 2'd0;
	localparam logic [1:0] PH_Y = 2'd1;
	localparam logic [1:0] PH_G = 2'd2;

	localparam logic [1:0] WALL_BOTTOM = 2'd0;
	localparam logic [1:0] WALL_RIGHT  = 2'd1;
	localparam logic [1:0] WALL_LEFT   = 2'd2;

	localparam logic signed [LINE_W-1:0] RAD_L = LINE_W'(BALL_RADIUS);

	// configuration registers
	logic [START_W-1:0] start_x_q, start_y_q;
	logic [VEL_W-1:0]   start_vx_q, start_vy_q;
	logic [DAMP_W-1:0]  damp_q;
	logic [FIELD_W-1:0] fw_q, fh_q;

	// ball state
	pos_t               ball_x_q, ball_y_q, prev_x_q, prev_y_q;
	vel_t               speed_x_q, speed_y_q;
	logic [CNT_W-1:0]   still_q;

	// sequencer
	logic [3:0]         state_q;
	logic [1:0]         phase_q, wall_q;
	logic               flip_x_q, flip_y_q, hit_q, div_neg_q;
	logic [XDIV_W-1:0]  xdiv_q;
	logic [QUO_W-1:0]   qest_q, quo_q;
	logic [MS_W-1:0]    ms_q;
	logic [1:0]         dir_q;
	logic [GRAV_W-1:0]  grav_q;

	// output register
	logic               out_valid_q, hit_out_q;
	pos_t               pos_x_q, pos_y_q;
	vel_t               vel_x_q, vel_y_q;
	logic [CNT_W-1:0]   still_out_q;

	logic               wr_en;
	logic [2:0]         reg_idx;
	mul_op_t            mul_a, mul_b;
	prod_t              prod;
	logic [VEL_W-1:0]   mag_x, mag_y, div_mag;
	logic               div_neg;
	logic [XDIV_W-1:0]  rem;
	logic               round_up;
	logic signed [SUM_W-1:0] quo_s, quo_app, px_sum, py_sum, g_base, g_sum;
	logic               g_sub;
	pos_t               wall_pos, line_sh, refl_pos;
	logic signed [LINE_W-1:0] line_h, line_w, wall_line, whole;
	logic               frac_up, wall_hit;
	logic signed [REFL_W-1:0] refl;
	logic signed [REFL_W+FRAC_W-1:0] refl_sh;
	logic [DMAG_W-1:0]  dmag;
	logic signed [SUM_W-1:0] dmag_s;
	vel_t               damp_x, damp_y;
	logic               out_busy, pos_same;
	logic [CNT_W-1:0]   still_next;

	// ---------------- configuration port ----------------
	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	always_comb begin
		unique case (reg_idx)
			REG_START_X:  prdata = DATA_W'(start_x_q);
			REG_START_Y:  prdata = DATA_W'(start_y_q);
			REG_START_VX: prdata = DATA_W'(start_vx_q);
			REG_START_VY: prdata = DATA_W'(start_vy_q);
			REG_DAMP:     prdata = DATA_W'(damp_q);
			REG_FIELD_W:  prdata = DATA_W'(fw_q);
			REG_FIELD_H:  prdata = DATA_W'(fh_q);
			default:      prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q  <= '0;
			start_y_q  <= '0;
			start_vx_q <= '0;
			start_vy_q <= '0;
			damp_q     <= DAMP_RESET;
			fw_q       <= FW_RESET;
			fh_q       <= FH_RESET;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_START_X:  start_x_q  <= pwdata[START_W-1:0];
				REG_START_Y:  start_y_q  <= pwdata[START_W-1:0];
				REG_START_VX: start_vx_q <= pwdata[VEL_W-1:0];
				REG_START_VY: start_vy_q <= pwdata[VEL_W-1:0];
				REG_DAMP:     damp_q     <= pwdata[DAMP_W-1:0];
				REG_FIELD_W:  fw_q       <= pwdata[FIELD_W-1:0];
				REG_FIELD_H:  fh_q       <= pwdata[FIELD_W-1:0];
				default: ;
			endcase
		end
	end

	// ---------------- shared multiplier ----------------
	bgbs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p_q (prod)
	);

	assign mag_x = speed_x_q[VEL_W-1] ? VEL_W'(-speed_x_q) : VEL_W'(speed_x_q);
	assign mag_y = speed_y_q[VEL_W-1] ? VEL_W'(-speed_y_q) : VEL_W'(speed_y_q);

	always_comb begin
		unique case (phase_q)
			PH_X: begin
				div_mag = mag_x;
				div_neg = speed_x_q[VEL_W-1];
			end
			PH_Y: begin
				div_mag = mag_y;
				div_neg = speed_y_q[VEL_W-1];
			end
			default: begin
				div_mag = VEL_W'(grav_q);
				div_neg = 1'b0;
			end
		endcase
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			ST_DIV_MUL: begin
				mul_a = MUL_W'(div_mag);
				mul_b = MUL_W'(ms_q);
			end
			ST_DIV_RCP: begin
				mul_a = MUL_W'(prod[DIV_SHIFT +: XDIV_W]);
				mul_b = RECIP_125;
			end
			ST_DIV_EST: begin
				mul_a = MUL_W'(prod[RECIP_SHIFT +: QUO_W]);
				mul_b = MUL_W'(DIV_ODD);
			end
			ST_DMP_X: begin
				mul_a = MUL_W'(mag_x);
				mul_b = MUL_W'(damp_q);
			end
			ST_DMP_Y: begin
				mul_a = MUL_W'(mag_y);
				mul_b = MUL_W'(damp_q);
			end
			default: ;
		endcase
	end

	// reciprocal estimate is exact or one low
	assign rem      = xdiv_q - prod[XDIV_W-1:0];
	assign round_up = (rem >= XDIV_W'(DIV_ODD));

	// ---------------- quotient application ----------------
	assign quo_s   = $signed({2'b00, quo_q});
	assign quo_app = div_neg_q ? -quo_s : quo_s;
	assign px_sum  = SUM_W'(ball_x_q) + quo_app;
	assign py_sum  = SUM_W'(ball_y_q) + quo_app;
	assign g_base  = dir_q[1] ? SUM_W'(speed_x_q) : SUM_W'(speed_y_q);
	assign g_sub   = (dir_q == GDIR_UP) || (dir_q == GDIR_LEFT);
	assign g_sum   = g_sub ? (g_base - quo_s) : (g_base + quo_s);

	// ---------------- wall reflection ----------------
	assign line_h = $signed({1'b0, fh_q}) - RAD_L;
	assign line_w = $signed({1'b0, fw_q}) - RAD_L;

	always_comb begin
		unique case (wall_q)
			WALL_BOTTOM: begin
				wall_pos  = ball_y_q;
				wall_line = line_h;
			end
			WALL_RIGHT: begin
				wall_pos  = ball_x_q;
				wall_line = line_w;
			end
			default: begin
				wall_pos  = ball_x_q;
				wall_line = RAD_L;
			end
		endcase
	end

	assign line_sh  = {wall_line, 8'h00};
	assign wall_hit = (wall_q == WALL_LEFT) ? (wall_pos < line_sh) : (wall_pos > line_sh);
	// whole pixels, truncated toward zero
	assign frac_up  = wall_pos[POS_W-1] && (wall_pos[FRAC_W-1:0] != '0);
	assign whole    = $signed(wall_pos[POS_W-1:FRAC_W]) + $signed({{(LINE_W-1){1'b0}}, frac_up});
	assign refl     = $signed({wall_line[LINE_W-1], wall_line, 1'b0})
	                - $signed({{(REFL_W-LINE_W){whole[LINE_W-1]}}, whole});
	assign refl_sh  = {refl, 8'h00};
	assign refl_pos = sat_pos(SUM_W'(refl_sh));

	// damped velocity: magnitude times damping, sign of the (possibly negated) component
	assign dmag    = prod[DAMP_SHIFT +: DMAG_W];
	assign dmag_s  = $signed({1'b0, dmag});
	assign damp_x  = sat_vel((speed_x_q[VEL_W-1] ^ flip_x_q) ? -dmag_s : dmag_s);
	assign damp_y  = sat_vel((speed_y_q[VEL_W-1] ^ flip_y_q) ? -dmag_s : dmag_s);

	// ---------------- finish ----------------
	assign out_busy   = out_valid_q && out_stall;
	assign pos_same   = (ball_x_q == prev_x_q) && (ball_y_q == prev_y_q);
	assign still_next = !pos_same ? '0 : ((still_q == CNT_MAX) ? CNT_MAX : still_q + 1'b1);

	assign in_stall = (state_q != ST_IDLE);

	// ---------------- sequencer and ball state ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			phase_q     <= PH_X;
			wall_q      <= WALL_BOTTOM;
			flip_x_q    <= 1'b0;
			flip_y_q    <= 1'b0;
			hit_q       <= 1'b0;
			div_neg_q   <= 1'b0;
			ball_x_q    <= '0;
			ball_y_q    <= '0;
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			speed_x_q   <= '0;
			speed_y_q   <= '0;
			still_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new word may replace the one taken at this edge
			if (state_q == ST_DONE && !out_busy)
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;

			if (wr_en) begin
				unique case (reg_idx)
					REG_START_X: begin
						ball_x_q <= pos_t'({1'b0, pwdata[START_W-1:0]});
						prev_x_q <= pos_t'({1'b0, pwdata[START_W-1:0]});
						still_q  <= '0;
					end
					REG_START_Y: begin
						ball_y_q <= pos_t'({1'b0, pwdata[START_W-1:0]});
						prev_y_q <= pos_t'({1'b0, pwdata[START_W-1:0]});
						still_q  <= '0;
					end
					REG_START_VX: speed_x_q <= pwdata[VEL_W-1:0];
					REG_START_VY: speed_y_q <= pwdata[VEL_W-1:0];
					default: ;
				endcase
			end

			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						phase_q <= PH_X;
						hit_q   <= 1'b0;
						state_q <= ST_DIV_MUL;
					end
				end
				ST_DIV_MUL: begin
					div_neg_q <= div_neg;
					state_q   <= ST_DIV_RCP;
				end
				ST_DIV_RCP: state_q <= ST_DIV_EST;
				ST_DIV_EST: state_q <= ST_DIV_FIX;
				ST_DIV_FIX: state_q <= ST_APPLY;
				ST_APPLY: begin
					unique case (phase_q)
						PH_X: begin
							ball_x_q <= sat_pos(px_sum);
							phase_q  <= PH_Y;
							state_q  <= ST_DIV_MUL;
						end
						PH_Y: begin
							ball_y_q <= sat_pos(py_sum);
							phase_q  <= PH_G;
							state_q  <= ST_DIV_MUL;
						end
						default: begin
							if (dir_q[1])
								speed_x_q <= sat_vel(g_sum);
							else
								speed_y_q <= sat_vel(g_sum);
							wall_q  <= WALL_BOTTOM;
							state_q <= ST_WALL;
						end
					endcase
				end
				ST_WALL: begin
					if (wall_hit) begin
						if (wall_q == WALL_BOTTOM) begin
							ball_y_q <= refl_pos;
							flip_x_q <= 1'b0;
							flip_y_q <= 1'b1;
						end else begin
							ball_x_q <= refl_pos;
							flip_x_q <= 1'b1;
							flip_y_q <= 1'b0;
						end
						hit_q   <= 1'b1;
						state_q <= ST_DMP_X;
					end else if (wall_q == WALL_LEFT) begin
						state_q <= ST_DONE;
					end else begin
						wall_q <= wall_q + 1'b1;
					end
				end
				ST_DMP_X: state_q <= ST_DMP_Y;
				ST_DMP_Y: begin
					speed_x_q <= damp_x;
					state_q   <= ST_DMP_END;
				end
				ST_DMP_END: begin
					speed_y_q <= damp_y;
					if (wall_q == WALL_LEFT) begin
						state_q <= ST_DONE;
					end else begin
						wall_q  <= wall_q + 1'b1;
						state_q <= ST_WALL;
					end
				end
				ST_DONE: begin
					if (!out_busy) begin
						still_q  <= still_next;
						prev_x_q <= ball_x_q;
						prev_y_q <= ball_y_q;
						state_q  <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && in_valid) begin
			ms_q   <= elapsed_ms;
			dir_q  <= gravity_dir;
			grav_q <= gravity_strength;
		end
		if (state_q == ST_DIV_RCP)
			xdiv_q <= prod[DIV_SHIFT +: XDIV_W];
		if (state_q == ST_DIV_EST)
			qest_q <= prod[RECIP_SHIFT +: QUO_W];
		if (state_q == ST_DIV_FIX)
			quo_q <= qest_q + QUO_W'(round_up);
		if (state_q == ST_DONE && !out_busy) begin
			pos_x_q     <= ball_x_q;
			pos_y_q     <= ball_y_q;
			vel_x_q     <= speed_x_q;
			vel_y_q     <= speed_y_q;
			hit_out_q   <= hit_q;
			still_out_q <= still_next;
		end
	end

	assign out_valid   = out_valid_q;
	assign pos_x       = pos_x_q;
	assign pos_y       = pos_y_q;
	assign vel_x       = vel_x_q;
	assign vel_y       = vel_y_q;
	assign hit_wall    = hit_out_q;
	assign still_ticks = still_out_q;

endmodule

// File: hdl/bgbs_chk.sv
// ----------------------------------------------------------------------------
// bgbs_chk: port-level checks for the ball bounce step block
// watches the tick and result handshakes over time
// ----------------------------------------------------------------------------
module bgbs_chk import bgbs_pkg::*; (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_stall,
	input logic                    out_valid,
	input logic                    out_stall,
	input logic signed [POS_W-1:0] pos_x,
	input logic signed [POS_W-1:0] pos_y,
	input logic signed [VEL_W-1:0] vel_x,
	input logic signed [VEL_W-1:0] vel_y,
	input logic                    hit_wall,
	input logic [CNT_W-1:0]        still_ticks
);

	// a taken tick word keeps the block busy next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("tick input not stalled after accept");

	// a new result only comes out of a busy block
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result word appeared without work in progress");

	// a stalled result word holds
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(pos_x) && $stable(pos_y)
			&& $stable(vel_x) && $stable(vel_y) && $stable(hit_wall)
			&& $stable(still_ticks)))
		else $error("stalled result word changed");

endmodule

bind ball_gravity_bounce_step bgbs_chk u_bgbs_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (in_valid),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.pos_x       (pos_x),
	.pos_y       (pos_y),
	.vel_x       (vel_x),
	.vel_y       (vel_y),
	.hit_wall    (hit_wall),
	.still_ticks (still_ticks)
);
